// ===== rtl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the text console: screen geometry, control
// codes, request and result layouts, command classes and back-end states.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COPY_CELLS = CELL_COUNT - COLUMNS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CUR_W  = $clog2(CELL_COUNT + 1);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int CURPOS_W = 11;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_BLANK_ATTR = '0;

    localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [CHAR_W-1:0]  char_code;
        logic [INDEX_W-1:0] cell_index;
    } tcc_in_t;

    typedef struct packed {
        logic [CURPOS_W-1:0] cursor_position;
        logic [CHAR_W-1:0]   cell_char;
        logic [ATTR_W-1:0]   cell_attr;
        logic                scrolled;
    } tcc_out_t;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_CR,
        OP_LF,
        OP_BS,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CHAR_W-1:0]  char_code;
        logic [INDEX_W-1:0] cell_index;
    } tcc_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tcc_qstat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY,
        ST_BLANK,
        ST_DONE
    } back_state_t;

endpackage

// ===== rtl/tcc_front.sv =====
// ----------------------------------------------------------------------------
// tcc_front
// Request intake: accepts requests while the queue has room and the screen
// store is not being cleared, and classifies each one into a command.
// ----------------------------------------------------------------------------
module tcc_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  tcc_pkg::tcc_in_t   s_data,
    input  logic               clear_busy,
    input  tcc_pkg::tcc_qstat_t qstat,
    output logic               push,
    output tcc_pkg::tcc_cmd_t  cmd
);
    import tcc_pkg::*;

    assign s_ready = !qstat.full && !clear_busy;
    assign push    = s_valid && s_ready;

    always_comb begin
        cmd.char_code  = s_data.char_code;
        cmd.cell_index = s_data.cell_index;
        if (s_data.kind == KIND_READ) begin
            cmd.op = OP_READ;
        end else begin
            unique case (s_data.char_code)
                CODE_CR: cmd.op = OP_CR;
                CODE_LF: cmd.op = OP_LF;
                CODE_BS: cmd.op = OP_BS;
                default: cmd.op = OP_PUT;
            endcase
        end
    end

endmodule

// ===== rtl/tcc_queue.sv =====
// ----------------------------------------------------------------------------
// tcc_queue
// Short command queue between the intake and the execution back end.
// ----------------------------------------------------------------------------
module tcc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tcc_pkg::tcc_cmd_t   push_cmd,
    input  logic                pop,
    output tcc_pkg::tcc_cmd_t   head_cmd,
    output tcc_pkg::tcc_qstat_t qstat
);
    import tcc_pkg::*;

    tcc_cmd_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign qstat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_cmd    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.full |-> !push || pop)
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !qstat.empty)
        else $error("queue popped while empty");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");
`endif

endmodule

// ===== rtl/tcc_back.sv =====
// ----------------------------------------------------------------------------
// tcc_back
// Execution back end: owns the screen store and the cursor, clears the store
// after reset, carries out commands, scrolls by sweeping the store and holds
// the result register.
// ----------------------------------------------------------------------------
module tcc_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [7:0]              blank_attr,
    input  logic                    q_valid,
    input  tcc_pkg::tcc_cmd_t       cmd,
    output logic                    q_pop,
    output logic                    clear_busy,
    output logic                    m_valid,
    input  logic                    m_ready,
    output tcc_pkg::tcc_out_t       m_data
);
    import tcc_pkg::*;

    logic [CHAR_W-1:0] char_mem [CELL_COUNT];
    logic [ATTR_W-1:0] attr_mem [CELL_COUNT];

    back_state_t       state_reg, state_next;
    logic [CUR_W-1:0]  cnt_reg, cnt_next;
    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              scroll_reg, scroll_next;
    logic              hit_reg, hit_next;
    logic              m_valid_reg, m_valid_next;
    tcc_out_t          m_data_reg, m_data_next;
    logic [CHAR_W-1:0] rd_char_reg;
    logic [ATTR_W-1:0] rd_attr_reg;

    logic              take;
    logic              out_free;
    logic              in_range;
    logic [CUR_W-1:0]  row_start;
    logic [CUR_W-1:0]  next_line;
    logic [CUR_W-1:0]  cursor_inc;
    logic [CUR_W-1:0]  copy_src;

    logic              mem_we_char, mem_we_attr, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [CHAR_W-1:0] mem_wchar;
    logic [ATTR_W-1:0] mem_wattr;

    assign take       = (state_reg == ST_IDLE) && q_valid;
    assign q_pop      = take;
    assign out_free   = !m_valid_reg || m_ready;
    assign clear_busy = (state_reg == ST_CLEAR);
    assign in_range   = (32'(cmd.cell_index) < CELL_COUNT);
    assign row_start  = cursor_reg - CUR_W'(col_reg);
    assign next_line  = row_start + CUR_W'(COLUMNS);
    assign cursor_inc = cursor_reg + 1'b1;
    assign copy_src   = cnt_reg + CUR_W'(COLUMNS);
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (cnt_reg == CUR_W'(CELL_COUNT - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_DONE;
                    if (cmd.op == OP_PUT && cursor_inc == CUR_W'(CELL_COUNT)) begin
                        state_next = ST_COPY;
                    end else if (cmd.op == OP_LF && next_line >= CUR_W'(CELL_COUNT)) begin
                        state_next = ST_COPY;
                    end
                end
            end
            ST_COPY: begin
                if (cnt_reg == CUR_W'(COPY_CELLS)) state_next = ST_BLANK;
            end
            ST_BLANK: begin
                if (cnt_reg == CUR_W'(CELL_COUNT - 1)) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // store port control
    always_comb begin
        mem_we_char = 1'b0;
        mem_we_attr = 1'b0;
        mem_waddr   = cursor_reg[ADDR_W-1:0];
        mem_wchar   = BLANK_CHAR;
        mem_wattr   = blank_attr;
        mem_re      = 1'b0;
        mem_raddr   = ADDR_W'(cmd.cell_index);
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we_char = 1'b1;
                mem_we_attr = 1'b1;
                mem_waddr   = cnt_reg[ADDR_W-1:0];
                mem_wattr   = RESET_ATTR;
            end
            ST_IDLE: begin
                if (q_valid) begin
                    unique case (cmd.op)
                        OP_READ: mem_re = in_range;
                        OP_PUT: begin
                            mem_we_char = 1'b1;
                            mem_wchar   = cmd.char_code;
                        end
                        OP_BS: begin
                            mem_we_char = 1'b1;
                            mem_we_attr = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_COPY: begin
                mem_re      = (cnt_reg != CUR_W'(COPY_CELLS));
                mem_raddr   = copy_src[ADDR_W-1:0];
                mem_we_char = (cnt_reg != '0);
                mem_we_attr = (cnt_reg != '0);
                mem_waddr   = ADDR_W'(cnt_reg - 1'b1);
                mem_wchar   = rd_char_reg;
                mem_wattr   = rd_attr_reg;
            end
            ST_BLANK: begin
                mem_we_char = 1'b1;
                mem_we_attr = 1'b1;
                mem_waddr   = cnt_reg[ADDR_W-1:0];
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    // cursor, sweep counter and result
    always_comb begin
        cnt_next     = cnt_reg;
        cursor_next  = cursor_reg;
        col_next     = col_reg;
        scroll_next  = scroll_reg;
        hit_next     = hit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            ST_CLEAR: cnt_next = cnt_reg + 1'b1;
            ST_IDLE: begin
                cnt_next = '0;
                if (take) begin
                    scroll_next = 1'b0;
                    hit_next    = (cmd.op == OP_READ) && in_range;
                    unique case (cmd.op)
                        OP_CR: begin
                            cursor_next = row_start;
                            col_next    = '0;
                        end
                        OP_LF: begin
                            col_next = '0;
                            if (next_line >= CUR_W'(CELL_COUNT)) begin
                                cursor_next = row_start;
                                scroll_next = 1'b1;
                            end else begin
                                cursor_next = next_line;
                            end
                        end
                        OP_BS: begin
                            if (cursor_reg != '0) begin
                                cursor_next = cursor_reg - 1'b1;
                                col_next    = (col_reg == '0) ? COL_W'(COLUMNS - 1)
                                                               : col_reg - 1'b1;
                            end
                        end
                        OP_PUT: begin
                            col_next = (col_reg == COL_W'(COLUMNS - 1)) ? '0
                                                                         : col_reg + 1'b1;
                            if (cursor_inc == CUR_W'(CELL_COUNT)) begin
                                cursor_next = CUR_W'(COPY_CELLS);
                                scroll_next = 1'b1;
                            end else begin
                                cursor_next = cursor_inc;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_COPY: begin
                if (cnt_reg != CUR_W'(COPY_CELLS)) cnt_next = cnt_reg + 1'b1;
            end
            ST_BLANK: cnt_next = cnt_reg + 1'b1;
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.cursor_position = CURPOS_W'(cursor_reg);
                    m_data_next.cell_char       = hit_reg ? rd_char_reg : '0;
                    m_data_next.cell_attr       = hit_reg ? rd_attr_reg : '0;
                    m_data_next.scrolled        = scroll_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            cursor_reg  <= '0;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cursor_reg  <= cursor_next;
            col_reg     <= col_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scroll_reg <= scroll_next;
        hit_reg    <= hit_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we_char) char_mem[mem_waddr] <= mem_wchar;
        if (mem_we_attr) attr_mem[mem_waddr] <= mem_wattr;
        if (mem_re) begin
            rd_char_reg <= char_mem[mem_raddr];
            rd_attr_reg <= attr_mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    a_cursor_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        (cursor_reg < CUR_W'(CELL_COUNT)) && (col_reg < COL_W'(COLUMNS)))
        else $error("cursor left the screen");

    a_write_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we_char || mem_we_attr) |-> (32'(mem_waddr) < CELL_COUNT))
        else $error("store write outside the screen");

    a_scroll_lands_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BLANK) |-> scroll_reg &&
            (cursor_reg >= CUR_W'(COPY_CELLS)) && (col_reg == '0))
        else $error("scroll with cursor off the bottom row start");

    a_pop_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == ST_DONE || state_reg == ST_COPY))
        else $error("command taken without execution");
`endif

endmodule

// ===== rtl/text_console_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text console of 80 x 25 character and attribute cells with a linear cursor,
// control code handling, one-row scrolling and cell read-back.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole store to blanks, one cell a cycle;
// s_ready stays low meanwhile, register writes are taken. An ordinary put,
// CR, LF, backspace or read then passes through two steps in the back end
// (issue, then result load); the back end takes no new command until the
// result of the last one has been loaded. A put or LF that scrolls also
// copies the store up one row, one cell a cycle, through its separate read
// and write ports, and then blanks the bottom row. A two-entry queue lets
// requests be taken while the back end is busy.
module text_console_cursor_scroll (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcc_pkg::PADDR_W-1:0]      paddr,
    input  logic [tcc_pkg::PDATA_W-1:0]      pwdata,
    output logic [tcc_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tcc_pkg::tcc_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tcc_pkg::tcc_out_t                m_data
);
    import tcc_pkg::*;

    logic [ATTR_W-1:0] blank_attr_reg, blank_attr_next;
    logic              reg_hit;
    logic              clear_busy;
    logic              push, pop;
    tcc_cmd_t          push_cmd, head_cmd;
    tcc_qstat_t        qstat;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_BLANK_ATTR);
    assign prdata  = reg_hit ? PDATA_W'(blank_attr_reg) : '0;

    always_comb begin
        blank_attr_next = blank_attr_reg;
        if (psel && penable && pwrite && pready && reg_hit) begin
            blank_attr_next = pwdata[ATTR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_attr_reg <= RESET_ATTR;
        end else begin
            blank_attr_reg <= blank_attr_next;
        end
    end

    tcc_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .clear_busy (clear_busy),
        .qstat      (qstat),
        .push       (push),
        .cmd        (push_cmd)
    );

    tcc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .qstat    (qstat)
    );

    tcc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .blank_attr (blank_attr_reg),
        .q_valid    (!qstat.empty),
        .cmd        (head_cmd),
        .q_pop      (pop),
        .clear_busy (clear_busy),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
